[rtl/core/assert_macros.svh]
// Assertion macros for the block's top-level RTL file.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/core/bdgrq_pkg.sv]
// Shared types and constants of the box downscale gray ramp quantiser.
// Depends on nothing.
package bdgrq_pkg;
  localparam int MAX_IMAGE_WIDTH  = 4096;
  localparam int MAX_IMAGE_HEIGHT = 4096;
  localparam int MAX_OUT_WIDTH    = 256;
  localparam int PW = 12;
  localparam int CW = 8;
  localparam int SUMW = 32;
  localparam int CNTW = 25;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_INVERT       = 3'd4;
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd5;
  localparam logic [2:0] REG_RAMP_LENGTH  = 3'd6;

  localparam logic [1:0] FMT_GRAY  = 2'd0;
  localparam logic [1:0] FMT_ALPHA = 2'd1;

  localparam logic [1:0] KIND_CELL  = 2'd0;
  localparam logic [1:0] KIND_BLANK = 2'd1;
  localparam logic [1:0] KIND_ROWS  = 2'd2;

  // Item passed from the front part to the back part.
  typedef struct packed {
    logic [7:0]    gray;
    logic [CW-1:0] cell_idx;
    logic          clear;
    logic          done;
    logic [12:0]   blank_rows;
    logic [12:0]   blank_cells;
    logic          row_end;
    logic          frame_end;
    logic          has_out;
  } work_t;
endpackage

[rtl/core/bdgrq_divu.sv]
// Sequential restoring divider, one quotient bit a cycle.
// Depends on bdgrq_pkg.
module bdgrq_divu import bdgrq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [39:0] den,
  output logic        busy,
  output logic [39:0] quo
);
  logic [39:0] q_r, q_nxt, rem_r, rem_nxt, d_r;
  logic [40:0] trial;
  logic [5:0]  cnt_r;
  logic        busy_r;

  // One restoring step per cycle.
  always_comb begin
    trial = {rem_r, q_r[39]};
    rem_nxt = trial[39:0];
    q_nxt = {q_r[38:0], 1'b0};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = 40'(trial - {1'b0, d_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd40;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      d_r <= den;
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo = q_r;
endmodule

[rtl/core/bdgrq_front.sv]
// Front part: frame geometry, pixel position, cell bounds and gray value.
// Depends on bdgrq_pkg and bdgrq_divu.
module bdgrq_front import bdgrq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [12:0] image_width,
  input  logic [12:0] image_height,
  input  logic [8:0]  out_width,
  input  logic [12:0] out_height,
  input  logic [1:0]  pixel_format,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        q_push,
  input  logic        q_full,
  output work_t       q_item
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_LATCH = 10'b0000000010, S_OH = 10'b0000000100,
    S_BAND = 10'b0000001000, S_CELL = 10'b0000010000, S_BND = 10'b0000100000,
    S_PREV = 10'b0001000000, S_GRAY = 10'b0010000000, S_PUSH = 10'b0100000000,
    S_WAIT = 10'b1000000000
  } st_t;

  st_t st_r;
  logic [PW:0] pc_r, pr_r, gw_r, gh_r, oh_r;
  logic [8:0]  gow_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic [PW:0] band_r, cell_r, ys_r, ye_r, xs_r, xe_r, pb_r, pc2_r;
  logic [3:0]  step_r;
  logic        dstart;
  logic [39:0] dnum, dden, dquo;
  logic        dbusy;
  logic [12:0] w_c, h_c;
  logic [8:0]  ow_c;
  logic [17:0] gsum;
  logic [36:0] gmul;
  logic [7:0]  gray_q;
  logic [PW:0] pcol, prow;
  work_t       item_r;

  bdgrq_divu u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                    .busy(dbusy), .quo(dquo));

  // Clamped live geometry values, combinational.
  assign w_c = (image_width == '0) ? 13'd1 :
               (image_width > 13'(MAX_IMAGE_WIDTH)) ? 13'(MAX_IMAGE_WIDTH) : image_width;
  assign h_c = (image_height == '0) ? 13'd1 :
               (image_height > 13'(MAX_IMAGE_HEIGHT)) ? 13'(MAX_IMAGE_HEIGHT) : image_height;
  assign ow_c = (out_width == '0) ? 9'd1 :
                (out_width > 9'(MAX_OUT_WIDTH)) ? 9'(MAX_OUT_WIDTH) : out_width;

  assign in_stall = (st_r != S_IDLE);
  assign pcol = (pc_r >= gw_r) ? '0 : pc_r;
  assign prow = (pr_r >= gh_r) ? '0 : pr_r;
  assign gsum = 18'(299 * red_r) + 18'(587 * green_r) + 18'(114 * blue_r);

  // Division of the weighted sum by 1000 through a reciprocal multiplication,
  // exact for every sum below 256000.
  assign gmul = 37'(gsum) * 37'd268436;
  assign gray_q = gmul[35:28];

  // Divider operand selection by step.
  always_comb begin
    dnum = '0;
    dden = 40'd1;
    unique case (step_r)
      4'd0: begin dnum = 40'(h_c) * 40'(ow_c); dden = 40'(w_c) * 40'd2; end
      4'd1: begin dnum = 40'((40'(pr_r) + 1) * 40'(oh_r) - 1); dden = 40'(gh_r); end
      4'd2: begin dnum = 40'((40'(pc_r) + 1) * 40'(gow_r) - 1); dden = 40'(gw_r); end
      4'd3: begin dnum = 40'(band_r) * 40'(gh_r); dden = 40'(oh_r); end
      4'd4: begin dnum = (40'(band_r) + 1) * 40'(gh_r); dden = 40'(oh_r); end
      4'd5: begin dnum = 40'(cell_r) * 40'(gw_r); dden = 40'(gow_r); end
      4'd6: begin dnum = (40'(cell_r) + 1) * 40'(gw_r); dden = 40'(gow_r); end
      4'd7: begin dnum = 40'(ys_r) * 40'(oh_r) - 1; dden = 40'(gh_r); end
      4'd8: begin dnum = 40'(xs_r) * 40'(gow_r) - 1; dden = 40'(gw_r); end
      default: ;
    endcase
  end

  assign dstart = (st_r == S_OH || st_r == S_BAND || st_r == S_CELL ||
                   st_r == S_BND || st_r == S_PREV) && !dbusy
                  && step_r[3:0] != 4'd15;

  // Sequencer: one divider job per step, results collected afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; step_r <= '0;
      pc_r <= '0; pr_r <= '0; gw_r <= 13'd1; gh_r <= 13'd1; gow_r <= 9'd1;
      oh_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          red_r <= in_red; green_r <= in_green; blue_r <= in_blue;
          if (pc_r == '0 && pr_r == '0) begin
            gw_r <= w_c; gh_r <= h_c; gow_r <= ow_c;
            if (out_height == '0) begin
              step_r <= 4'd0; st_r <= S_OH;
            end else begin
              // A given row count saturates like a derived one.
              oh_r <= (out_height > 13'(MAX_IMAGE_HEIGHT)) ? 13'(MAX_IMAGE_HEIGHT)
                                                          : out_height;
              st_r <= S_LATCH;
            end
          end else st_r <= S_LATCH;
        end
        S_LATCH: begin
          pc_r <= pcol; pr_r <= prow;
          step_r <= 4'd1;
          st_r <= (oh_r == '0) ? S_GRAY : S_BAND;
        end
        S_OH: begin
          st_r <= S_WAIT; step_r <= 4'd15;
        end
        S_BAND, S_CELL, S_BND, S_PREV: begin
          st_r <= S_WAIT;
        end
        S_WAIT: if (!dbusy && !dstart) begin
          case (step_r)
            4'd15: begin
              oh_r <= (dquo > 40'(MAX_IMAGE_HEIGHT)) ? 13'(MAX_IMAGE_HEIGHT) : 13'(dquo);
              st_r <= S_LATCH;
            end
            4'd1: begin
              band_r <= (dquo > 40'(oh_r - 1)) ? 13'(oh_r - 1) : 13'(dquo);
              step_r <= 4'd2; st_r <= S_CELL;
            end
            4'd2: begin
              cell_r <= (dquo > 40'(gow_r - 1)) ? 13'(gow_r - 1) : 13'(dquo);
              step_r <= 4'd3; st_r <= S_BND;
            end
            4'd3: begin ys_r <= 13'(dquo); step_r <= 4'd4; st_r <= S_BND; end
            4'd4: begin ye_r <= 13'(dquo); step_r <= 4'd5; st_r <= S_BND; end
            4'd5: begin xs_r <= 13'(dquo); step_r <= 4'd6; st_r <= S_BND; end
            4'd6: begin
              xe_r <= 13'(dquo);
              step_r <= 4'd7; st_r <= S_PREV;
            end
            4'd7: begin
              pb_r <= (dquo > 40'(oh_r - 1)) ? 13'(oh_r - 1) : 13'(dquo);
              step_r <= 4'd8; st_r <= S_PREV;
            end
            4'd8: begin
              pc2_r <= (dquo > 40'(gow_r - 1)) ? 13'(gow_r - 1) : 13'(dquo);
              st_r <= S_GRAY;
            end
            default: st_r <= S_GRAY;
          endcase
        end
        // Gray value and the classification of the pixel's cell.
        S_GRAY: begin
          item_r.gray <= (pixel_format == FMT_GRAY) ? red_r :
                         (pixel_format == FMT_ALPHA) ? 8'd0 : gray_q;
          item_r.cell_idx <= CW'(cell_r);
          item_r.clear <= (pr_r == ys_r) && (pc_r == xs_r);
          item_r.done <= (pr_r + 1 == ye_r) && (pc_r + 1 == xe_r);
          item_r.blank_rows <= (xs_r != '0) ? '0 :
                               (ys_r == '0) ? band_r : 13'(band_r - pb_r - 1);
          item_r.blank_cells <= (xs_r == '0) ? cell_r : 13'(cell_r - pc2_r - 1);
          item_r.row_end <= (cell_r + 1 == 13'(gow_r));
          item_r.frame_end <= (cell_r + 1 == 13'(gow_r)) && (band_r + 1 == oh_r);
          item_r.has_out <= (oh_r != '0);
          st_r <= S_PUSH;
        end
        S_PUSH: if (!q_full) begin
          if (pc_r + 1 >= gw_r) begin
            pc_r <= '0;
            pr_r <= (pr_r + 1 >= gh_r) ? '0 : pr_r + 1;
          end else pc_r <= pc_r + 1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign q_push = (st_r == S_PUSH) && !q_full;
  assign q_item = item_r;
endmodule

[rtl/core/bdgrq_back.sv]
// Back part: column accumulators, cell averages and result emission.
// Depends on bdgrq_pkg and bdgrq_divu.
module bdgrq_back import bdgrq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        invert,
  input  logic [7:0]  ramp_length,
  input  logic        q_valid,
  input  work_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_level,
  output logic [12:0] out_run_count,
  output logic        out_row_end,
  output logic        out_frame_end,
  output logic        out_last
);
  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001, B_RD = 7'b0000010, B_ACC = 7'b0000100,
    B_AVG = 7'b0001000, B_AW = 7'b0010000, B_LVL = 7'b0100000,
    B_OUT = 7'b1000000
  } bst_t;

  bst_t st_r;
  work_t it_r;
  logic [SUMW-1:0] sum_mem [MAX_OUT_WIDTH];
  logic [CNTW-1:0] cnt_mem [MAX_OUT_WIDTH];
  logic [SUMW-1:0] sum_rd, sum_r;
  logic [CNTW-1:0] cnt_rd, cnt_r;
  logic [CW-1:0]   rd_addr;
  logic [7:0]  avg_r, lvl_r;
  logic [1:0]  phase_r;
  logic        dstart;
  logic [39:0] dnum, dden, dquo;
  logic        dbusy;
  logic [7:0]  len;
  logic [15:0] lvl_prod;
  logic [32:0] lvl_mul;
  logic [7:0]  lvl_q;

  bdgrq_divu u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                    .busy(dbusy), .quo(dquo));

  assign len = (ramp_length == '0) ? 8'd1 : ramp_length;
  assign dstart = (st_r == B_AVG);
  assign dnum = 40'(sum_r);
  assign dden = (cnt_r == '0) ? 40'd1 : 40'(cnt_r);
  assign q_pop = (st_r == B_IDLE) && q_valid;

  // Ramp scaling: division by 255 through a reciprocal multiplication,
  // exact for every product below 65280.
  assign lvl_prod = 16'(avg_r) * 16'(len - 8'd1);
  assign lvl_mul = 33'(lvl_prod) * 33'd65794;
  assign lvl_q = lvl_mul[31:24];

  // The read address follows the incoming transaction while idle.
  assign rd_addr = (st_r == B_IDLE) ? q_item.cell_idx : it_r.cell_idx;

  // Accumulator memory: registered read, single write.
  always_ff @(posedge clk) begin
    sum_rd <= sum_mem[rd_addr];
    cnt_rd <= cnt_mem[rd_addr];
    if (st_r == B_ACC) begin
      sum_mem[it_r.cell_idx] <= sum_r;
      cnt_mem[it_r.cell_idx] <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; phase_r <= '0;
    end else begin
      unique case (st_r)
        B_IDLE: if (q_valid) begin it_r <= q_item; st_r <= B_RD; end
        B_RD: st_r <= it_r.has_out ? B_ACC : B_IDLE;
        B_ACC: begin
          st_r <= it_r.done ? B_AVG : B_IDLE;
        end
        B_AVG: st_r <= B_AW;
        B_AW: if (!dbusy) begin
          avg_r <= (dquo > 40'd255) ? 8'd255 : (invert ? ~dquo[7:0] : dquo[7:0]);
          if (dquo > 40'd255 && invert) avg_r <= 8'd0;
          st_r <= B_LVL;
        end
        B_LVL: begin
          lvl_r <= (lvl_q > len - 8'd1) ? len - 8'd1 : lvl_q;
          phase_r <= (it_r.blank_rows != '0) ? 2'd0 :
                     (it_r.blank_cells != '0) ? 2'd1 : 2'd2;
          st_r <= B_OUT;
        end
        B_OUT: if (!out_stall) begin
          if (phase_r == 2'd0) phase_r <= (it_r.blank_cells != '0) ? 2'd1 : 2'd2;
          else if (phase_r == 2'd1) phase_r <= 2'd2;
          else st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // Sum and count update, using the read data unless the cell restarts.
  always_ff @(posedge clk) begin
    if (st_r == B_RD) begin
      sum_r <= (it_r.clear ? '0 : sum_rd) + SUMW'(it_r.gray);
      cnt_r <= (it_r.clear ? '0 : cnt_rd) + CNTW'(1);
    end
  end

  assign out_valid = (st_r == B_OUT);
  assign out_kind = (phase_r == 2'd0) ? KIND_ROWS :
                    (phase_r == 2'd1) ? KIND_BLANK : KIND_CELL;
  assign out_level = (phase_r == 2'd2) ? lvl_r : 8'd0;
  assign out_run_count = (phase_r == 2'd0) ? it_r.blank_rows :
                         (phase_r == 2'd1) ? it_r.blank_cells : 13'd1;
  assign out_row_end = (phase_r == 2'd0) ? 1'b1 :
                       (phase_r == 2'd1) ? 1'b0 : it_r.row_end;
  assign out_frame_end = (phase_r == 2'd2) && it_r.frame_end;
  assign out_last = (phase_r == 2'd2);
endmodule

[rtl/core/bdgrq_fifo.sv]
// Two-entry queue of work items between the front and back parts.
// Depends on bdgrq_pkg.
module bdgrq_fifo import bdgrq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output work_t dout
);
  work_t mem_r [2];
  logic  wp_r, rp_r;
  logic [1:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; n_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      n_r <= n_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign full = (n_r == 2'd2);
  assign valid = (n_r != 2'd0);
  assign dout = mem_r[rp_r];
endmodule

[rtl/core/box_downscale_gray_ramp_quantizer_top.sv]
// Channel   | Direction | Ports
// pixel     | in        | in_valid, in_stall, in_red, in_green, in_blue
// result    | out       | out_valid, out_stall, out_kind .. out_last
// config    | in        | cfg_we, cfg_index, cfg_data
// In the front part a pixel runs through eight 40-step divisions, none when
// the frame has no output rows, and one more at a frame start when the row
// count is derived.
// In the back part a completing cell runs through one 40-step division for the
// average, and each blank run ahead of it goes out as a result of its own.
// Reset is synchronous and active low; the accumulators need no clearing.
// Results wait while out_stall is high; the queue lets the front run ahead.
// Top level; depends on bdgrq_pkg, bdgrq_front, bdgrq_back, bdgrq_fifo.
`include "assert_macros.svh"
module box_downscale_gray_ramp_quantizer_top import bdgrq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_level,
  output logic [12:0] out_run_count,
  output logic        out_row_end,
  output logic        out_frame_end,
  output logic        out_last
);
  logic [12:0] iw_r, ih_r, oh_r;
  logic [8:0]  ow_r;
  logic        inv_r;
  logic [1:0]  fmt_r;
  logic [7:0]  len_r;
  logic        push, full, pop, qv;
  work_t       qin, qout;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= 13'd1; ih_r <= 13'd1; ow_r <= 9'd80; oh_r <= '0;
      inv_r <= 1'b0; fmt_r <= 2'd2; len_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  iw_r <= cfg_data;
        REG_IMAGE_HEIGHT: ih_r <= cfg_data;
        REG_OUT_WIDTH:    ow_r <= cfg_data[8:0];
        REG_OUT_HEIGHT:   oh_r <= cfg_data;
        REG_INVERT:       inv_r <= cfg_data[0];
        REG_PIXEL_FORMAT: fmt_r <= cfg_data[1:0];
        REG_RAMP_LENGTH:  len_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bdgrq_front u_front (.clk, .rst_n, .image_width(iw_r), .image_height(ih_r),
    .out_width(ow_r), .out_height(oh_r), .pixel_format(fmt_r), .in_valid,
    .in_stall, .in_red, .in_green, .in_blue, .q_push(push), .q_full(full),
    .q_item(qin));

  bdgrq_fifo u_fifo (.clk, .rst_n, .push, .din(qin), .full, .pop, .valid(qv),
    .dout(qout));

  bdgrq_back u_back (.clk, .rst_n, .invert(inv_r), .ramp_length(len_r),
    .q_valid(qv), .q_item(qout), .q_pop(pop), .out_valid, .out_stall,
    .out_kind, .out_level, .out_run_count, .out_row_end, .out_frame_end,
    .out_last);

  `CHK_IMPLY(a_no_push_full, clk, rst_n, full, !push)
  `CHK_IMPLY(a_frame_row, clk, rst_n, out_valid && out_frame_end, out_row_end && out_last)
  `CHK_IMPLY(a_cell_count, clk, rst_n, out_valid && out_kind == KIND_CELL, out_run_count == 13'd1)
endmodule

[tb/sv/tb_box_downscale_gray_ramp_quantizer_top.sv]
// Self-checking testbench of the box downscale gray ramp quantiser top level.
// Pixels are driven in bursts, every result transaction is compared with a
// predictor of the cell averaging; depends on bdgrq_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_box_downscale_gray_ramp_quantizer_top;
  import bdgrq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_level;
  logic [12:0] out_run_count;
  logic        out_row_end;
  logic        out_frame_end;
  logic        out_last;

  box_downscale_gray_ramp_quantizer_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_level(out_level), .out_run_count(out_run_count),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end), .out_last(out_last)
  );

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  level;
    logic [12:0] run_count;
    logic        row_end;
    logic        frame_end;
    logic        last;
  } cell_res_t;

  // Shadow registers and predictor state.
  logic [12:0] sh_w, sh_h, sh_oh;
  logic [8:0]  sh_ow;
  logic        sh_inv;
  logic [1:0]  sh_fmt;
  logic [7:0]  sh_len;
  longint unsigned col_sum [MAX_OUT_WIDTH];
  int unsigned col_cnt [MAX_OUT_WIDTH];
  int unsigned pix_x, pix_y, rows_used, fr_w, fr_h, fr_ow;

  cell_res_t expected_cells[$];
  int errors, mismatches, cycles_idle, rx_count;
  bit hold_rx;

  // Directed pixels: red, green and blue of each pixel.
  typedef struct {
    logic [7:0] r, g, b;
  } pix_row_t;
  pix_row_t pix_table[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned part_idx(int unsigned p, int unsigned n, int unsigned span);
    longint unsigned k;
    k = ((longint'(p) + 1) * n - 1) / span;
    if (k > n - 1) k = n - 1;
    return int'(k);
  endfunction

  function automatic int unsigned part_lo(int unsigned i, int unsigned n, int unsigned span);
    return int'((longint'(i) * span) / n);
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  sh_w = val[12:0];
      REG_IMAGE_HEIGHT: sh_h = val[12:0];
      REG_OUT_WIDTH:    sh_ow = val[8:0];
      REG_OUT_HEIGHT:   sh_oh = val[12:0];
      REG_INVERT:       sh_inv = val[0];
      REG_PIXEL_FORMAT: sh_fmt = val[1:0];
      REG_RAMP_LENGTH:  sh_len = val[7:0];
      default: ;
    endcase
  endtask

  // Predicts the results caused by one accepted pixel.
  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gray, px, py, band, cell_i, ys, ye, xs, xe, nbr, nbc, avg, len, lvl, cnt;
    longint unsigned oh;
    cell_res_t res;
    if (pix_x == 0 && pix_y == 0) begin
      fr_w = clampv(sh_w, 1, MAX_IMAGE_WIDTH);
      fr_h = clampv(sh_h, 1, MAX_IMAGE_HEIGHT);
      fr_ow = clampv(sh_ow, 1, MAX_OUT_WIDTH);
      if (sh_oh == 0) oh = (longint'(fr_h) * fr_ow) / (longint'(fr_w) * 2);
      else oh = sh_oh;
      if (oh > MAX_IMAGE_HEIGHT) oh = MAX_IMAGE_HEIGHT;
      rows_used = int'(oh);
    end
    if (pix_x >= fr_w) pix_x = 0;
    if (pix_y >= fr_h) pix_y = 0;
    px = pix_x;
    py = pix_y;
    if (sh_fmt == FMT_GRAY) gray = r;
    else if (sh_fmt == FMT_ALPHA) gray = 0;
    else gray = (299 * r + 587 * g + 114 * b) / 1000;
    if (rows_used != 0) begin
      band = part_idx(py, rows_used, fr_h);
      cell_i = part_idx(px, fr_ow, fr_w);
      ys = part_lo(band, rows_used, fr_h);
      ye = part_lo(band + 1, rows_used, fr_h);
      xs = part_lo(cell_i, fr_ow, fr_w);
      xe = part_lo(cell_i + 1, fr_ow, fr_w);
      if (py == ys && px == xs) begin
        col_sum[cell_i] = 0;
        col_cnt[cell_i] = 0;
      end
      col_sum[cell_i] += gray;
      col_cnt[cell_i] = (col_cnt[cell_i] + 1) & 32'h1FF_FFFF;
      if (py + 1 == ye && px + 1 == xe) begin
        if (xs == 0) begin
          nbr = (ys == 0) ? band : band - part_idx(ys - 1, rows_used, fr_h) - 1;
          if (nbr != 0) begin
            res = '{KIND_ROWS, 8'd0, nbr[12:0], 1'b1, 1'b0, 1'b0};
            expected_cells.push_back(res);
          end
        end
        nbc = (xs == 0) ? cell_i : cell_i - part_idx(xs - 1, fr_ow, fr_w) - 1;
        if (nbc != 0) begin
          res = '{KIND_BLANK, 8'd0, nbc[12:0], 1'b0, 1'b0, 1'b0};
          expected_cells.push_back(res);
        end
        cnt = col_cnt[cell_i] ? col_cnt[cell_i] : 1;
        avg = int'(col_sum[cell_i] / cnt);
        if (avg > 255) avg = 255;
        if (sh_inv) avg = 255 - avg;
        len = sh_len ? sh_len : 1;
        lvl = (avg * (len - 1)) / 255;
        if (lvl > len - 1) lvl = len - 1;
        res.kind = KIND_CELL;
        res.level = lvl[7:0];
        res.run_count = 13'd1;
        res.row_end = (cell_i + 1 == fr_ow);
        res.frame_end = (cell_i + 1 == fr_ow) && (band + 1 == rows_used);
        res.last = 1'b1;
        expected_cells.push_back(res);
      end
    end
    pix_x = px + 1;
    if (pix_x >= fr_w) begin
      pix_x = 0;
      pix_y = py + 1;
      if (pix_y >= fr_h) pix_y = 0;
    end
  endtask

  // Offers one pixel and waits for its transaction.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    predict_pixel(r, g, b);
  endtask

  // Sends n pixels in random bursts; directed rows come from the table.
  task automatic send_stream(input int n, input bit directed);
    int burst;
    int gap;
    pix_row_t p;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      if (directed) p = pix_table[i];
      else if ($urandom_range(0, 7) == 0)
        p = '{($urandom_range(0, 1) ? 8'hFF : 8'h00),
              ($urandom_range(0, 1) ? 8'hFF : 8'h00),
              ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      else p = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255))};
      send_pixel(p.r, p.g, p.b);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // Pauses until every expected result has come, then lets the block settle.
  task automatic drain;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // Writes all registers and sends one or more complete frames.
  task automatic run_frames(input int unsigned w, input int unsigned h,
                            input int unsigned ow, input int unsigned oh,
                            input int frames);
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    cfg_write(REG_OUT_WIDTH, ow);
    cfg_write(REG_OUT_HEIGHT, oh);
    cfg_write(REG_INVERT, $urandom_range(0, 1));
    cfg_write(REG_PIXEL_FORMAT, $urandom_range(0, 3));
    cfg_write(REG_RAMP_LENGTH, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 20));
    send_stream(clampv(w, 1, MAX_IMAGE_WIDTH) * clampv(h, 1, MAX_IMAGE_HEIGHT) * frames, 1'b0);
    drain();
  endtask

  // Receiver: random stall pattern, one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (6000) @(posedge clk);
        hold_rx = 1'b0;
      end
      out_stall <= ($urandom_range(0, 9) < 3) && ($urandom_range(0, 40) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cell_res_t got, exp_cell;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_level, out_run_count, out_row_end, out_frame_end, out_last};
      rx_count++;
      if (expected_cells.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %p", got);
      end else begin
        exp_cell = expected_cells.pop_front();
        if (got !== exp_cell) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_cell, got);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) cycles_idle = 0;
    else cycles_idle++;
    if (cycles_idle > 40000) begin
      $display("box_downscale_gray_ramp_quantizer_top test failed");
      $finish;
    end
  end

  initial begin
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    rst_n = 1'b0;
    sh_w = 1; sh_h = 1; sh_ow = 80; sh_oh = 0; sh_inv = 0; sh_fmt = 2; sh_len = 10;
    pix_x = 0; pix_y = 0; rows_used = 0; fr_w = 1; fr_h = 1; fr_ow = 1;
    errors = 0; mismatches = 0; cycles_idle = 0; rx_count = 0;
    hold_rx = 0;
    for (int i = 0; i < MAX_OUT_WIDTH; i++) begin
      col_sum[i] = 0;
      col_cnt[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: a 1x1 frame with 80 cells derives 40 rows; one white pixel
    // gives 39 blank rows, 79 blank cells and the last cell at level 9.
    pix_table.push_back('{8'hFF, 8'hFF, 8'hFF});
    send_stream(1, 1'b1);
    if (expected_cells.size() != 3 || expected_cells[2].level != 8'd9) begin
      errors++;
      $display("Reset prediction differs from the typed result");
    end
    drain();

    // Directed: extremes of every field in gray, alpha and colour format.
    pix_table.delete();
    for (int i = 0; i < 24; i++)
      pix_table.push_back('{(i[0] ? 8'hFF : 8'h00), (i[1] ? 8'hFF : 8'h00),
                            (i[2] ? 8'hFF : 8'h55 << i[3])});
    cfg_write(REG_IMAGE_WIDTH, 4);
    cfg_write(REG_IMAGE_HEIGHT, 2);
    cfg_write(REG_OUT_WIDTH, 4);
    cfg_write(REG_OUT_HEIGHT, 2);
    cfg_write(REG_INVERT, 0);
    cfg_write(REG_PIXEL_FORMAT, FMT_GRAY);
    cfg_write(REG_RAMP_LENGTH, 255);
    send_stream(8, 1'b1);
    drain();
    cfg_write(REG_INVERT, 1);
    cfg_write(REG_PIXEL_FORMAT, FMT_ALPHA);
    cfg_write(REG_RAMP_LENGTH, 0);
    send_stream(8, 1'b1);
    drain();
    cfg_write(REG_PIXEL_FORMAT, 3);
    cfg_write(REG_RAMP_LENGTH, 1);
    cfg_write(7, 5);
    send_stream(8, 1'b1);
    drain();

    // Random geometries: downscale, upscale, zero rows, clamped registers.
    run_frames(8, 6, 3, 2, 2);
    run_frames(3, 5, 7, 9, 1);
    run_frames(2, 2, 1, 0, 3);
    run_frames(1, 1, 0, 5000, 2);
    run_frames(16, 2, 4, 0, 1);
    run_frames(0, 4, 2, 3, 2);
    run_frames(6, 3, 256, 1, 1);
    for (int f = 0; f < 17; f++)
      run_frames($urandom_range(1, 8), $urandom_range(1, 5), $urandom_range(1, 9),
                 $urandom_range(0, 4), 1);

    // Long receiver hold-off while pixels keep coming, so the queue fills.
    cfg_write(REG_IMAGE_WIDTH, 4);
    cfg_write(REG_IMAGE_HEIGHT, 4);
    cfg_write(REG_OUT_WIDTH, 4);
    cfg_write(REG_OUT_HEIGHT, 4);
    hold_rx = 1'b1;
    send_stream(48, 1'b0);
    drain();

    $display("Covered gray, alpha and colour pixels, inversion, ramp extremes, blank runs,");
    $display("derived and clamped geometry, %0d results checked.", rx_count);
    if (errors == 0 && expected_cells.size() == 0)
      $display("box_downscale_gray_ramp_quantizer_top test passed");
    else
      $display("box_downscale_gray_ramp_quantizer_top test failed");
    $finish;
  end
endmodule

[box_downscale_gray_ramp_quantizer_top.f]
+incdir+rtl/core
rtl/core/bdgrq_pkg.sv
rtl/core/bdgrq_divu.sv
rtl/core/bdgrq_front.sv
rtl/core/bdgrq_back.sv
rtl/core/bdgrq_fifo.sv
rtl/core/box_downscale_gray_ramp_quantizer_top.sv
tb/sv/tb_box_downscale_gray_ramp_quantizer_top.sv
